FILE: hdl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Types and constants shared by the event ring consumer and its slot table.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int SLOT_COUNT_DEF = 256;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_BASE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_ENTRIES = 1'd1;

  localparam logic [8:0] RING_ENTRIES_RST = 9'd256;

  // descriptor type codes
  localparam logic [5:0] TRB_TRANSFER = 6'd32;
  localparam logic [5:0] TRB_COMMAND  = 6'd33;
  localparam logic [5:0] TRB_PORT     = 6'd34;

  typedef enum logic [2:0] {
    KIND_BATCH_END = 3'd0,
    KIND_COMMAND   = 3'd1,
    KIND_PORT      = 3'd2,
    KIND_TRANSFER  = 3'd3,
    KIND_OTHER     = 3'd4,
    KIND_QUERY     = 3'd5
  } result_kind_t;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] trb_status;
    logic [31:0] trb_control;
    logic [7:0]  query_slot;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic        pointer_write;
    logic [63:0] pointer_value;
    logic [7:0]  status_code;
    logic [7:0]  slot_number;
    logic [4:0]  endpoint_number;
    logic [23:0] byte_length;
    logic [5:0]  event_type;
    logic        slot_finished;
    logic        command_finished;
    logic        ring_phase;
    logic [47:0] total_events;
  } rsp_item_t;

  // write side of the per-slot transfer table
  typedef struct packed {
    logic        en;
    logic [7:0]  slot;
    logic [23:0] len;
  } tbl_wr_t;

endpackage

FILE: hdl/erc_slot_table.sv
// ----------------------------------------------------------------------------
// erc_slot_table
// Per-slot transfer length memory with per-entry done flags. A slot whose
// done flag is clear reads as length 0, so the memory needs no clearing.
// ----------------------------------------------------------------------------
module erc_slot_table #(
  parameter int SLOT_COUNT = erc_pkg::SLOT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  erc_pkg::tbl_wr_t wr,
  input  logic            rd_en,
  input  logic [7:0]      rd_slot,
  output logic [23:0]     rd_len,
  output logic            rd_done
);
  import erc_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [23:0]           len_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] done;
  logic [23:0]           rd_len_q;
  logic                  rd_hit;
  logic                  wr_in_range;
  logic                  rd_in_range;
  logic [SLOT_W-1:0]     wr_idx;
  logic [SLOT_W-1:0]     rd_idx;

  assign wr_in_range = {1'b0, wr.slot} < 9'(SLOT_COUNT);
  assign rd_in_range = {1'b0, rd_slot} < 9'(SLOT_COUNT);
  assign wr_idx      = SLOT_W'(wr.slot);
  assign rd_idx      = SLOT_W'(rd_slot);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      len_mem[wr_idx] <= wr.len;
    end
    if (rd_en) begin
      rd_len_q <= len_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        done[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= rd_in_range && done[rd_idx];
      end
    end
  end

  assign rd_len  = rd_hit ? rd_len_q : 24'd0;
  assign rd_done = rd_hit;

endmodule

FILE: hdl/event_ring_consumer_core.sv
// ----------------------------------------------------------------------------
// event_ring_consumer_core
// Consumer side of a cycle-bit event ring with a per-slot transfer table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries either an event descriptor fetched at the current
//   dequeue slot or a query of one slot's transfer entry. rsp channel
//   returns exactly one result per request, in order.
//   The result is registered: a request transferred at a clock edge shows
//   its result on rsp from that edge on. Throughput is one request per
//   cycle while rsp is not stalled; the slot table memory is written at
//   request time and read into a register beside the result register, so
//   a new request goes in at the same edge the previous result is taken.
//   When rsp is stalled the result holds and req_stall is raised until the
//   result is taken; nothing is dropped.
//   Reset clears the dequeue index, event count and command status, sets
//   the cycle state to one, and marks every slot entry empty (per-entry
//   done flags); no clearing pass is needed.
//   Configuration writes (ring base, ring size) are taken at any edge with
//   cfg_wr_en high and should only happen while the block is idle.
// ----------------------------------------------------------------------------
module event_ring_consumer_core #(
  parameter int RING_DEPTH = erc_pkg::RING_DEPTH_DEF,
  parameter int SLOT_COUNT = erc_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  erc_pkg::req_item_t               req_data,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output erc_pkg::rsp_item_t               rsp_data,
  input  logic                             cfg_wr_en,
  input  logic [erc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [erc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import erc_pkg::*;

  localparam int RING_CAP = (RING_DEPTH < 256) ? RING_DEPTH : 256;

  // configuration
  logic [63:0] ring_base;
  logic [8:0]  ring_entries;

  // scalar ring state
  logic [7:0]  dequeue_index;
  logic        ring_cycle;
  logic        batch_pending;
  logic [47:0] event_count;
  logic [7:0]  last_command_code;
  logic        command_seen;

  logic [7:0]  dequeue_index_next;
  logic        ring_cycle_next;
  logic        batch_pending_next;
  logic [47:0] event_count_next;
  logic [7:0]  last_command_code_next;
  logic        command_seen_next;

  logic        accept;
  logic [8:0]  ring_limit;
  logic [8:0]  index_inc;
  logic [5:0]  trb_type;
  rsp_item_t   rsp_next;
  rsp_item_t   rsp_q;
  logic        rsp_is_query;
  tbl_wr_t     tbl_wr;
  logic [23:0] tbl_len;
  logic        tbl_done;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base    <= '0;
      ring_entries <= RING_ENTRIES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RING_BASE:    ring_base    <= cfg_wdata;
        CFG_RING_ENTRIES: ring_entries <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign ring_limit = (ring_entries == 9'd0 || ring_entries > 9'(RING_CAP)) ?
                      9'(RING_CAP) : ring_entries;
  assign index_inc  = {1'b0, dequeue_index} + 9'd1;
  assign trb_type   = req_data.trb_control[15:10];

  always_comb begin
    dequeue_index_next     = dequeue_index;
    ring_cycle_next        = ring_cycle;
    batch_pending_next     = batch_pending;
    event_count_next       = event_count;
    last_command_code_next = last_command_code;
    command_seen_next      = command_seen;
    rsp_next               = '0;
    tbl_wr                 = '0;
    tbl_wr.slot            = req_data.trb_control[31:24];
    tbl_wr.len             = req_data.trb_status[23:0];

    if (req_data.req_type == REQ_QUERY) begin
      rsp_next.result_kind = KIND_QUERY;
      rsp_next.status_code = last_command_code;
      rsp_next.slot_number = req_data.query_slot;
    end else if (req_data.trb_control[0] != ring_cycle) begin
      // producer has not written this slot yet: close the batch
      rsp_next.result_kind = KIND_BATCH_END;
      if (batch_pending) begin
        rsp_next.pointer_write = 1'b1;
        rsp_next.pointer_value = {ring_base[63:4] + 60'(dequeue_index), 4'b1000};
        batch_pending_next     = 1'b0;
      end
    end else begin
      rsp_next.event_type  = trb_type;
      rsp_next.status_code = req_data.trb_status[31:24];
      rsp_next.slot_number = req_data.trb_control[31:24];
      case (trb_type)
        TRB_COMMAND: begin
          rsp_next.result_kind   = KIND_COMMAND;
          last_command_code_next = req_data.trb_status[31:24];
          command_seen_next      = 1'b1;
        end
        TRB_PORT: begin
          rsp_next.result_kind = KIND_PORT;
        end
        TRB_TRANSFER: begin
          rsp_next.result_kind     = KIND_TRANSFER;
          rsp_next.endpoint_number = req_data.trb_control[20:16];
          rsp_next.byte_length     = req_data.trb_status[23:0];
          tbl_wr.en                = 1'b1;
        end
        default: begin
          rsp_next.result_kind = KIND_OTHER;
        end
      endcase
      if (index_inc >= ring_limit) begin
        dequeue_index_next = 8'd0;
        ring_cycle_next    = ~ring_cycle;
      end else begin
        dequeue_index_next = index_inc[7:0];
      end
      event_count_next   = event_count + 48'd1;
      batch_pending_next = 1'b1;
    end

    rsp_next.command_finished = command_seen_next;
    rsp_next.ring_phase       = ring_cycle_next;
    rsp_next.total_events     = event_count_next;
    tbl_wr.en                 = tbl_wr.en && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dequeue_index     <= '0;
      ring_cycle        <= 1'b1;
      batch_pending     <= 1'b0;
      event_count       <= '0;
      last_command_code <= '0;
      command_seen      <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (accept) begin
        dequeue_index     <= dequeue_index_next;
        ring_cycle        <= ring_cycle_next;
        batch_pending     <= batch_pending_next;
        event_count       <= event_count_next;
        last_command_code <= last_command_code_next;
        command_seen      <= command_seen_next;
        rsp_valid         <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_q        <= rsp_next;
      rsp_is_query <= (req_data.req_type == REQ_QUERY);
    end
  end

  // table read issued at transfer time; its data arrives with the result
  erc_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (accept),
    .rd_slot (req_data.query_slot),
    .rd_len  (tbl_len),
    .rd_done (tbl_done)
  );

  always_comb begin
    rsp_data = rsp_q;
    if (rsp_is_query) begin
      rsp_data.byte_length   = tbl_len;
      rsp_data.slot_finished = tbl_done;
    end
  end

endmodule
